// File: hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and codes for the source text lexer: beat payloads, token
// kinds, error codes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package stl_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ESCAPE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MARK   = 2'd1;

  // token kinds
  localparam logic [3:0] K_STRING = 4'd0;
  localparam logic [3:0] K_IDENT  = 4'd1;
  localparam logic [3:0] K_INT    = 4'd2;
  localparam logic [3:0] K_DEC    = 4'd3;
  localparam logic [3:0] K_LE     = 4'd4;
  localparam logic [3:0] K_LT     = 4'd5;
  localparam logic [3:0] K_GE     = 4'd6;
  localparam logic [3:0] K_GT     = 4'd7;
  localparam logic [3:0] K_EQEQ   = 4'd8;
  localparam logic [3:0] K_EQ     = 4'd9;
  localparam logic [3:0] K_NE     = 4'd10;
  localparam logic [3:0] K_BANG   = 4'd11;
  localparam logic [3:0] K_SINGLE = 4'd12;
  localparam logic [3:0] K_EOS    = 4'd13;
  localparam logic [3:0] K_ERR    = 4'd14;

  // error codes
  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_NONASCII = 2'd1;
  localparam logic [1:0] E_MARK2    = 2'd2;
  localparam logic [1:0] E_UNTERM   = 2'd3;

  // records per byte and record queue sizing
  localparam int REC_SLOTS  = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = 2;
  localparam int Q_CNT_BITS = 3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  rec_kind;
    logic [6:0]  char_code;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [15:0] line_num;
    logic [15:0] column_num;
    logic [1:0]  error_code;
    logic        last_result;
  } out_item_t;

  // all records caused by one byte
  typedef struct packed {
    logic [1:0]                     rec_cnt;
    out_item_t [REC_SLOTS-1:0]      recs;
  } bundle_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    bundle_t bund;
  } q_head_t;

endpackage

// File: hdl/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front
// Scanner front end: holds the lexer state and the configuration registers,
// classifies each accepted byte and builds, combinationally, the records it causes.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int POS_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  stl_pkg::in_item_t                 in_data,
  input  logic                              cfg_fire,
  input  logic [stl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [6:0]                        cfg_data,
  output logic                              push,
  output stl_pkg::bundle_t                  push_data
);
  import stl_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_STRING = 3'd1;
  localparam logic [2:0] M_IDENT  = 3'd2;
  localparam logic [2:0] M_OPER   = 3'd3;
  localparam logic [2:0] M_MINUS  = 3'd4;
  localparam logic [2:0] M_DIGIT  = 3'd5;
  localparam logic [2:0] M_MARK   = 3'd6;

  localparam logic [6:0] CH_SQUOTE = 7'h27;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_LT     = 7'h3C;
  localparam logic [6:0] CH_GT     = 7'h3E;
  localparam logic [6:0] CH_EQ     = 7'h3D;
  localparam logic [6:0] CH_BANG   = 7'h21;
  localparam logic [6:0] CH_MINUS  = 7'h2D;
  localparam logic [6:0] CH_USCORE = 7'h5F;
  localparam logic [6:0] CH_NL     = 7'h0A;

  localparam logic [6:0] ESC_RESET  = 7'd92;
  localparam logic [6:0] MARK_RESET = 7'd46;

  logic [6:0]          esc_r, mark_r;
  logic [2:0]          mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] tstart_r, tstart_nxt;
  logic [15:0]         line_r, line_nxt;
  logic [POS_BITS-1:0] lbeg_r, lbeg_nxt;
  logic [6:0]          held_r, held_nxt;
  logic [1:0]          flags_r, flags_nxt;
  logic                halted_r, halted_nxt;

  // working copies while one byte walks through the scanner
  logic [2:0]          mode_w;
  logic [POS_BITS-1:0] ts_w, lb_w, pos1, pos_end;
  logic [15:0]         ln_w;
  logic [6:0]          held_w;
  logic [1:0]          fl_w;
  logic                hlt_w, new_tok;
  logic [7:0]          b;
  logic [6:0]          c;
  logic                fin, is_ascii, is_alpha, is_digit, is_word;
  out_item_t           cand [4];
  logic [3:0]          cand_v;
  logic [1:0]          cnt;
  bundle_t             bund;

  function automatic logic [15:0] lo16(logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic out_item_t make_rec(logic [3:0] kind, logic [6:0] code,
                                         logic [POS_BITS-1:0] start,
                                         logic [POS_BITS-1:0] len,
                                         logic [15:0] line,
                                         logic [POS_BITS-1:0] lbeg,
                                         logic [1:0] err);
    out_item_t           r;
    logic [POS_BITS-1:0] col;
    col           = start - lbeg;
    r.rec_kind    = kind;
    r.char_code   = code;
    r.start_pos   = lo16(start);
    r.token_len   = lo16(len);
    r.line_num    = line;
    r.column_num  = lo16(col);
    r.error_code  = err;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] op_kind(logic [6:0] op, logic two);
    logic [3:0] k;
    case (op)
      CH_LT:   k = two ? K_LE : K_LT;
      CH_GT:   k = two ? K_GE : K_GT;
      CH_EQ:   k = two ? K_EQEQ : K_EQ;
      default: k = two ? K_NE : K_BANG;
    endcase
    return k;
  endfunction

  always_comb begin
    b        = in_data.text_byte;
    fin      = in_data.final_byte;
    c        = b[6:0];
    is_ascii = ~b[7];
    is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    is_digit = (b >= 8'h30 && b <= 8'h39);
    is_word  = is_alpha || is_digit || (b == {1'b0, CH_USCORE});

    mode_w  = mode_r;
    ts_w    = tstart_r;
    ln_w    = line_r;
    lb_w    = lbeg_r;
    held_w  = held_r;
    fl_w    = flags_r;
    hlt_w   = halted_r;
    pos1    = pos_r + 1'b1;
    pos_end = pos1;
    new_tok = 1'b0;
    cand_v  = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (!halted_r) begin
      // slot 0: the pending token reacts to this byte
      if (mode_r == M_IDLE) begin
        new_tok = 1'b1;
      end else begin
        case (mode_r)
          M_STRING: begin
            if (b == {1'b0, held_r} && flags_r == 2'd0) begin
              cand[0] = make_rec(K_STRING, 7'd0, ts_w, pos_r - ts_w, ln_w, lb_w, E_NONE);
              cand_v[0] = 1'b1;
              mode_w = M_IDLE;
            end else begin
              fl_w = {1'b0, b == {1'b0, esc_r}};
            end
          end
          M_IDENT: begin
            if (!is_word) begin
              cand[0] = make_rec(K_IDENT, 7'd0, ts_w, pos_r - ts_w, ln_w, lb_w, E_NONE);
              cand_v[0] = 1'b1;
              mode_w  = M_IDLE;
              new_tok = 1'b1;
            end
          end
          M_OPER: begin
            mode_w = M_IDLE;
            cand_v[0] = 1'b1;
            if (b == {1'b0, CH_EQ}) begin
              cand[0] = make_rec(op_kind(held_r, 1'b1), 7'd0, ts_w, POS_BITS'(2), ln_w,
                                 lb_w, E_NONE);
            end else begin
              cand[0] = make_rec(op_kind(held_r, 1'b0), 7'd0, ts_w, POS_BITS'(1), ln_w,
                                 lb_w, E_NONE);
              new_tok = 1'b1;
            end
          end
          M_MINUS: begin
            if (is_digit) begin
              mode_w = M_DIGIT;
            end else begin
              cand[0] = make_rec(K_SINGLE, CH_MINUS, ts_w, POS_BITS'(1), ln_w, lb_w, E_NONE);
              cand_v[0] = 1'b1;
              mode_w  = M_IDLE;
              new_tok = 1'b1;
            end
          end
          M_DIGIT: begin
            if (b == {1'b0, mark_r}) begin
              if (flags_r[0]) begin
                cand[0] = make_rec(K_ERR, 7'd0, ts_w, pos1 - ts_w, ln_w, lb_w, E_MARK2);
                cand_v[0] = 1'b1;
                hlt_w  = 1'b1;
                mode_w = M_IDLE;
              end else begin
                fl_w[0] = 1'b1;
                mode_w  = M_MARK;
              end
            end else if (!is_digit) begin
              cand[0] = make_rec(flags_r[0] ? K_DEC : K_INT, 7'd0, ts_w, pos_r - ts_w, ln_w,
                                 lb_w, E_NONE);
              cand_v[0] = 1'b1;
              mode_w  = M_IDLE;
              new_tok = 1'b1;
            end
          end
          M_MARK: begin
            if (is_digit) begin
              mode_w = M_DIGIT;
            end else begin
              cand[0] = make_rec(flags_r[0] ? K_DEC : K_INT, 7'd0, ts_w, pos_r - ts_w, ln_w,
                                 lb_w, E_NONE);
              cand_v[0] = 1'b1;
              mode_w  = M_IDLE;
              new_tok = 1'b1;
            end
          end
          default: begin
            mode_w  = M_IDLE;
            new_tok = 1'b1;
          end
        endcase
      end

      // slot 1: this byte opens a token
      if (new_tok) begin
        ts_w = pos_r;
        if (!is_ascii) begin
          cand[1] = make_rec(K_ERR, 7'd0, pos_r, pos1 - pos_r, ln_w, lb_w, E_NONASCII);
          cand_v[1] = 1'b1;
          hlt_w  = 1'b1;
          mode_w = M_IDLE;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          mode_w = M_STRING;
          held_w = c;
          fl_w   = {1'b0, c == esc_r};
          ts_w   = pos1;
        end else if (c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG) begin
          mode_w = M_OPER;
          held_w = c;
        end else if (is_alpha || c == CH_USCORE) begin
          mode_w = M_IDENT;
        end else if (is_digit) begin
          mode_w = M_DIGIT;
          fl_w   = 2'd0;
        end else if (c == CH_MINUS) begin
          mode_w = M_MINUS;
          fl_w   = 2'd2;
        end else begin
          // newline record already carries the advanced line
          if (c == CH_NL) begin
            if (ln_w != 16'hFFFF) begin
              ln_w = ln_w + 16'd1;
            end
            lb_w = pos1;
          end
          cand[1] = make_rec(K_SINGLE, c, pos_r, POS_BITS'(1), ln_w, lb_w, E_NONE);
          cand_v[1] = 1'b1;
        end
      end

      // slots 2 and 3: flush and end of stream on the last byte
      if (fin && !hlt_w) begin
        case (mode_w)
          M_STRING: begin
            cand[2] = make_rec(K_ERR, 7'd0, ts_w, pos_end - ts_w, ln_w, lb_w, E_UNTERM);
            cand_v[2] = 1'b1;
            hlt_w = 1'b1;
          end
          M_IDENT: begin
            cand[2] = make_rec(K_IDENT, 7'd0, ts_w, pos_end - ts_w, ln_w, lb_w, E_NONE);
            cand_v[2] = 1'b1;
          end
          M_OPER: begin
            cand[2] = make_rec(op_kind(held_w, 1'b0), 7'd0, ts_w, POS_BITS'(1), ln_w, lb_w,
                               E_NONE);
            cand_v[2] = 1'b1;
          end
          M_MINUS: begin
            cand[2] = make_rec(K_SINGLE, CH_MINUS, ts_w, POS_BITS'(1), ln_w, lb_w, E_NONE);
            cand_v[2] = 1'b1;
          end
          M_DIGIT, M_MARK: begin
            cand[2] = make_rec(fl_w[0] ? K_DEC : K_INT, 7'd0, ts_w, pos_end - ts_w, ln_w,
                               lb_w, E_NONE);
            cand_v[2] = 1'b1;
          end
          default: begin
          end
        endcase
        if (!hlt_w) begin
          cand[3] = make_rec(K_EOS, 7'd0, pos_end, POS_BITS'(1), ln_w, lb_w, E_NONE);
          cand_v[3] = 1'b1;
        end
        mode_w = M_IDLE;
      end
    end

    // pack the valid slots in order, at most three per byte
    bund = '0;
    cnt  = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && cnt != 2'd3) begin
        bund.recs[cnt] = cand[i];
        cnt = cnt + 2'd1;
      end
    end
    if (cnt != 2'd0) begin
      bund.recs[cnt - 2'd1].last_result = 1'b1;
    end
    bund.rec_cnt = cnt;

    if (fin) begin
      mode_nxt   = M_IDLE;
      pos_nxt    = '0;
      tstart_nxt = '0;
      line_nxt   = 16'd1;
      lbeg_nxt   = '0;
      held_nxt   = 7'd0;
      flags_nxt  = 2'd0;
      halted_nxt = 1'b0;
    end else begin
      mode_nxt   = mode_w;
      pos_nxt    = pos1;
      tstart_nxt = ts_w;
      line_nxt   = ln_w;
      lbeg_nxt   = lb_w;
      held_nxt   = held_w;
      flags_nxt  = fl_w;
      halted_nxt = hlt_w;
    end
  end

  assign push      = in_fire && (cnt != 2'd0);
  assign push_data = bund;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      line_r   <= 16'd1;
      lbeg_r   <= '0;
      held_r   <= 7'd0;
      flags_r  <= 2'd0;
      halted_r <= 1'b0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      line_r   <= line_nxt;
      lbeg_r   <= lbeg_nxt;
      held_r   <= held_nxt;
      flags_r  <= flags_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= ESC_RESET;
      mark_r <= MARK_RESET;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_ESCAPE) begin
        esc_r <= cfg_data;
      end else if (cfg_index == CFG_MARK) begin
        mark_r <= cfg_data;
      end
    end
  end

  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> mode_r == M_IDLE)
    else $error("halted scanner holds a pending token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0)
    else $error("line count reached zero");

  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.final_byte |=> pos_r == '0 && line_r == 16'd1 && !halted_r)
    else $error("scanner did not restart after the last byte");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.final_byte |=> pos_r == POS_BITS'($past(pos_r) + 1'b1))
    else $error("position did not advance by one");

endmodule

// File: hdl/stl_fifo.sv
// ----------------------------------------------------------------------------
// stl_fifo
// Small queue of record bundles between the scanner and the output drain,
// one bundle per byte that caused records.
// ----------------------------------------------------------------------------
module stl_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stl_pkg::bundle_t  push_data,
  input  logic              pop,
  output logic              full,
  output stl_pkg::q_head_t  head
);
  import stl_pkg::*;

  bundle_t                q_mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.bund  = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// File: hdl/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back
// Output drain: walks the records of the bundle at the queue head, one beat
// per cycle while out_ready is high, and releases the bundle after its last record.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  stl_pkg::q_head_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output stl_pkg::out_item_t  out_data
);
  import stl_pkg::*;

  logic [1:0] sub_r, sub_nxt;
  logic       out_fire, at_last;

  assign out_valid = head.valid;
  assign out_data  = head.bund.recs[sub_r];
  assign out_fire  = out_valid && out_ready;
  assign at_last   = (sub_r == head.bund.rec_cnt - 2'd1);
  assign pop       = out_fire && at_last;

  always_comb begin
    sub_nxt = sub_r;
    if (out_fire) begin
      sub_nxt = at_last ? 2'd0 : sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 2'd0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

// File: hdl/source_text_lexer_core.sv
// ----------------------------------------------------------------------------
// source_text_lexer_core
// Byte-in, token-record-out lexer with a decoupled scanner and output drain.
// ----------------------------------------------------------------------------
// The scanner takes one source byte per cycle and turns it, in that same
// cycle, into the zero to three token records it causes; these go as one
// bundle into a four-entry queue, and the drain sends one record per cycle on
// the output while it is ready. A byte is accepted whenever the queue has
// room, so the input runs at one byte per cycle as long as bytes average at
// most one record; a byte that causes k records holds the output for k beats,
// and the queue rides out bursts of up to four such bytes. A record appears
// on the output the cycle after its byte is accepted at the earliest.
// Configuration writes are always taken and act on the next byte.
module source_text_lexer_core #(
  parameter int POS_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  stl_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output stl_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [6:0]                        cfg_data
);
  import stl_pkg::*;

  logic     push, pop, full, in_fire;
  bundle_t  push_data;
  q_head_t  head;

  assign in_ready  = !full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  stl_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data)
  );

  stl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  stl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
